FILE: rtl/alu16_pkg.sv
// alu16_pkg: widths, opcodes and pipeline record types of the 16-bit alu
// no dependencies; compiled first

package alu16_pkg;

    localparam int DATA_W        = 16;
    localparam int OP_W          = 5;
    localparam int SHAMT_W       = $clog2(DATA_W);
    localparam int DIV_STEP_BITS = 4;
    localparam int DIV_STAGES    = DATA_W / DIV_STEP_BITS;

    localparam logic [OP_W-1:0] OP_ADD = 5'd0;
    localparam logic [OP_W-1:0] OP_SUB = 5'd1;
    localparam logic [OP_W-1:0] OP_LSR = 5'd2;
    localparam logic [OP_W-1:0] OP_LSL = 5'd3;
    localparam logic [OP_W-1:0] OP_ASR = 5'd4;
    localparam logic [OP_W-1:0] OP_MOV = 5'd5;
    localparam logic [OP_W-1:0] OP_MUL = 5'd6;
    localparam logic [OP_W-1:0] OP_DIV = 5'd7;
    localparam logic [OP_W-1:0] OP_MOD = 5'd8;
    localparam logic [OP_W-1:0] OP_AND = 5'd9;
    localparam logic [OP_W-1:0] OP_OR  = 5'd10;
    localparam logic [OP_W-1:0] OP_XOR = 5'd11;
    localparam logic [OP_W-1:0] OP_NOT = 5'd12;
    localparam logic [OP_W-1:0] OP_CMP = 5'd13;
    localparam logic [OP_W-1:0] OP_INC = 5'd14;
    localparam logic [OP_W-1:0] OP_DEC = 5'd15;

    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] quo;
        logic [DATA_W-1:0] dvs;
    } div_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] result;
        logic              carry;
        logic              overflow;
        div_t              div;
    } pipe_t;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              zero;
        logic              negative;
        logic              carry;
        logic              overflow;
    } res_t;

endpackage

FILE: rtl/alu16_if.sv
// alu16_in_if / alu16_out_if: valid/ready channels of the alu
// depends on alu16_pkg

interface alu16_in_if
    import alu16_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] operand_a;
    logic [DATA_W-1:0] operand_b;

    modport source (output valid, output op, output operand_a, output operand_b, input ready);
    modport sink   (input valid, input op, input operand_a, input operand_b, output ready);
endinterface

interface alu16_out_if
    import alu16_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] alu_result;
    logic              zero_flag;
    logic              negative_flag;
    logic              carry_flag;
    logic              overflow_flag;

    modport source (output valid, output alu_result, output zero_flag, output negative_flag,
                    output carry_flag, output overflow_flag, input ready);
    modport sink   (input valid, input alu_result, input zero_flag, input negative_flag,
                    input carry_flag, input overflow_flag, output ready);
endinterface

FILE: rtl/alu16_front.sv
// alu16_front: simple operations, low-half multiply and divider setup
// depends on alu16_pkg

module alu16_front
    import alu16_pkg::*;
(
    input  logic [OP_W-1:0]   op,
    input  logic [DATA_W-1:0] operand_a,
    input  logic [DATA_W-1:0] operand_b,
    output pipe_t             pipe
);

    logic [DATA_W:0]      sum;
    logic [DATA_W:0]      diff;
    logic [DATA_W-1:0]    prod;
    logic [SHAMT_W-1:0]   shamt;
    logic                 flush;

    assign sum   = {1'b0, operand_a} + {1'b0, operand_b};
    assign diff  = {1'b0, operand_a} - {1'b0, operand_b};
    assign prod  = operand_a * operand_b;
    assign shamt = operand_b[SHAMT_W-1:0];
    assign flush = |operand_b[DATA_W-1:SHAMT_W];

    always_comb
    begin
        pipe.op       = op;
        pipe.result   = '1;
        pipe.carry    = 1'b0;
        pipe.overflow = 1'b0;
        pipe.div.rem  = '0;
        pipe.div.quo  = operand_a;
        pipe.div.dvs  = operand_b;
        case (op)
            OP_ADD:
            begin
                pipe.result   = sum[DATA_W-1:0];
                pipe.carry    = sum[DATA_W];
                pipe.overflow = (operand_a[DATA_W-1] == operand_b[DATA_W-1])
                              && (sum[DATA_W-1] != operand_a[DATA_W-1]);
            end
            OP_SUB:
            begin
                pipe.result   = diff[DATA_W-1:0];
                pipe.carry    = diff[DATA_W];
                pipe.overflow = (operand_a[DATA_W-1] != operand_b[DATA_W-1])
                              && (diff[DATA_W-1] != operand_a[DATA_W-1]);
            end
            OP_LSR:
            begin
                pipe.result = flush ? '0 : (operand_a >> shamt);
                pipe.carry  = operand_a[0];
            end
            OP_LSL:
            begin
                pipe.result = flush ? '0 : (operand_a << shamt);
            end
            OP_ASR:
            begin
                pipe.result = flush ? {DATA_W{operand_a[DATA_W-1]}}
                                    : DATA_W'($signed(operand_a) >>> shamt);
                pipe.carry  = operand_a[0];
            end
            OP_MOV: pipe.result = operand_b;
            OP_MUL: pipe.result = prod;
            OP_DIV: pipe.result = '1;
            OP_MOD: pipe.result = '1;
            OP_AND: pipe.result = operand_a & operand_b;
            OP_OR:  pipe.result = operand_a | operand_b;
            OP_XOR: pipe.result = operand_a ^ operand_b;
            OP_NOT: pipe.result = ~operand_a;
            OP_CMP: pipe.result = diff[DATA_W-1:0];
            OP_INC: pipe.result = operand_a + {{(DATA_W-1){1'b0}}, 1'b1};
            OP_DEC: pipe.result = operand_a - {{(DATA_W-1){1'b0}}, 1'b1};
            default: pipe.result = '1;
        endcase
    end

endmodule

FILE: rtl/alu16_div_step.sv
// alu16_div_step: four restoring division steps for one divider stage
// depends on alu16_pkg

module alu16_div_step
    import alu16_pkg::*;
(
    input  div_t d_in,
    output div_t d_out
);

    always_comb
    begin
        div_t          d;
        logic [DATA_W:0] t;
        logic          qbit;
        d = d_in;
        for (int i = 0; i < DIV_STEP_BITS; i++)
        begin
            t = {d.rem, d.quo[DATA_W-1]};
            if (t >= {1'b0, d.dvs})
            begin
                t    = t - {1'b0, d.dvs};
                qbit = 1'b1;
            end
            else
            begin
                qbit = 1'b0;
            end
            d.rem = t[DATA_W-1:0];
            d.quo = {d.quo[DATA_W-2:0], qbit};
        end
        d_out = d;
    end

endmodule

FILE: rtl/alu16_with_flags_top.sv
// Stateless 16-bit alu with zero, negative, carry and overflow flags. One transfer
// is taken on cmd every cycle unless rsp back-pressure stalls the pipe, and each gives
// exactly one transfer on rsp, in order. Stages: a register after the front stage (simple
// operations and the low-half multiply), four divider stages of four quotient bits
// each, then the result and flag register. Each stage holds its item while the
// one after it is full and stalled, so bubbles close up and nothing is lost.
// depends on alu16_pkg, alu16_if, alu16_front, alu16_div_step

module alu16_with_flags_top
    import alu16_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    alu16_in_if.sink      cmd,
    alu16_out_if.source   rsp
);

    pipe_t               front_out;
    pipe_t               stage_reg  [DIV_STAGES+1];
    pipe_t               stage_next [DIV_STAGES+1];
    div_t                div_out    [DIV_STAGES];
    logic [DIV_STAGES:0] valid_reg;
    logic [DIV_STAGES:0] adv;
    logic                out_adv;
    logic                out_valid_reg;
    res_t                out_reg;
    res_t                out_next;

    alu16_front u_front
    (
        .op        (cmd.op),
        .operand_a (cmd.operand_a),
        .operand_b (cmd.operand_b),
        .pipe      (front_out)
    );

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        alu16_div_step u_div_step
        (
            .d_in  (stage_reg[k].div),
            .d_out (div_out[k])
        );
    end

    always_comb
    begin
        stage_next[0] = front_out;
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            stage_next[k+1]     = stage_reg[k];
            stage_next[k+1].div = div_out[k];
        end
    end

    // stall chain
    always_comb
    begin
        out_adv         = !out_valid_reg || rsp.ready;
        adv[DIV_STAGES] = !valid_reg[DIV_STAGES] || out_adv;
        for (int k = DIV_STAGES - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign cmd.ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= cmd.valid;
            end
            for (int k = 1; k <= DIV_STAGES; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
            if (out_adv)
            begin
                out_valid_reg <= valid_reg[DIV_STAGES];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= DIV_STAGES; k++)
        begin
            if (adv[k])
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
        if (out_adv)
        begin
            out_reg <= out_next;
        end
    end

    // result select and flags
    always_comb
    begin
        pipe_t s;
        s = stage_reg[DIV_STAGES];
        case (s.op)
            OP_DIV:  out_next.result = (s.div.dvs == '0) ? '1 : s.div.quo;
            OP_MOD:  out_next.result = (s.div.dvs == '0) ? '1 : s.div.rem;
            default: out_next.result = s.result;
        endcase
        out_next.zero     = (out_next.result == '0);
        out_next.negative = out_next.result[DATA_W-1];
        out_next.carry    = s.carry;
        out_next.overflow = s.overflow;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.alu_result    = out_reg.result;
    assign rsp.zero_flag     = out_reg.zero;
    assign rsp.negative_flag = out_reg.negative;
    assign rsp.carry_flag    = out_reg.carry;
    assign rsp.overflow_flag = out_reg.overflow;

endmodule

FILE: sim/testbench.sv
// testbench for alu16_with_flags_top: directed corner cases, then random bursts against a
// built-in predictor, with receiver stalls and one long hold-off on the result channel
// depends on alu16_pkg, alu16_in_if, alu16_out_if and the alu rtl
`timescale 1ns / 100ps

module testbench;
    import alu16_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_ITEMS  = 1700;
    localparam int MAX_PRINTS    = 40;
    localparam logic [DATA_W-1:0] ALL_ONES = '1;
    localparam logic [DATA_W-1:0] SIGN_BIT = 16'h8000;

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

    logic clk;
    logic rst_n;

    alu16_in_if  cmd_if ();
    alu16_out_if rsp_if ();

    alu16_with_flags_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if.sink),
        .rsp   (rsp_if.source)
    );

    res_t     expected_results[$];
    int       mismatch_count = 0;
    int       items_sent     = 0;
    int       results_seen   = 0;
    int       cycle_count    = 0;
    int       longest_hold   = 0;
    rx_mode_t rx_mode        = RX_ALWAYS;
    logic     hold_req       = 1'b0;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                 expected_results.size());
        $display("Test completed with failures");
        $finish;
    end

    function automatic res_t alu_predict(input logic [OP_W-1:0] op,
                                         input logic [DATA_W-1:0] a,
                                         input logic [DATA_W-1:0] b);
        logic [DATA_W:0]   wide;
        logic [DATA_W-1:0] r;
        logic              c;
        logic              v;
        res_t              res;
        c = 1'b0;
        v = 1'b0;
        case (op)
            OP_ADD:
            begin
                wide = {1'b0, a} + {1'b0, b};
                r    = wide[DATA_W-1:0];
                c    = wide[DATA_W];
                v    = (a[15] == b[15]) && (r[15] != a[15]);
            end
            OP_SUB:
            begin
                r = a - b;
                c = (a < b);
                v = (a[15] != b[15]) && (r[15] != a[15]);
            end
            OP_LSR:
            begin
                r = (b >= DATA_W) ? '0 : (a >> b);
                c = a[0];
            end
            OP_LSL:  r = (b >= DATA_W) ? '0 : (a << b);
            OP_ASR:
            begin
                r = (b >= DATA_W) ? {DATA_W{a[15]}} : DATA_W'($signed(a) >>> b);
                c = a[0];
            end
            OP_MOV:  r = b;
            OP_MUL:  r = DATA_W'(a * b);
            OP_DIV:  r = (b == '0) ? ALL_ONES : a / b;
            OP_MOD:  r = (b == '0) ? ALL_ONES : a % b;
            OP_AND:  r = a & b;
            OP_OR:   r = a | b;
            OP_XOR:  r = a ^ b;
            OP_NOT:  r = ~a;
            OP_CMP:  r = a - b;
            OP_INC:  r = a + 1'b1;
            OP_DEC:  r = a - 1'b1;
            default: r = ALL_ONES;
        endcase
        res.result   = r;
        res.zero     = (r == '0);
        res.negative = r[15];
        res.carry    = c;
        res.overflow = v;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("result %0d: %s got %h expected %h", results_seen, what, got, want);
    endtask

    // result channel: own stall pattern, plus a long hold-off on request
    initial
    begin
        int   tick;
        int   hold_left;
        logic hold_seen;
        tick      = 0;
        hold_left = 0;
        hold_seen = 1'b0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
                longest_hold = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_ALWAYS:  rsp_if.ready <= 1'b1;
                    RX_RANDOM:  rsp_if.ready <= ($urandom_range(0, 99) < 60);
                    RX_PATTERN: rsp_if.ready <= ((tick % 7) < 4);
                    default:    rsp_if.ready <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected transfer, result", rsp_if.alu_result, '0);
            else
            begin
                want = expected_results.pop_front();
                if (rsp_if.alu_result !== want.result)
                    report_mismatch("alu_result", rsp_if.alu_result, want.result);
                if (rsp_if.zero_flag !== want.zero)
                    report_mismatch("zero_flag", DATA_W'(rsp_if.zero_flag),
                                    DATA_W'(want.zero));
                if (rsp_if.negative_flag !== want.negative)
                    report_mismatch("negative_flag", DATA_W'(rsp_if.negative_flag),
                                    DATA_W'(want.negative));
                if (rsp_if.carry_flag !== want.carry)
                    report_mismatch("carry_flag", DATA_W'(rsp_if.carry_flag),
                                    DATA_W'(want.carry));
                if (rsp_if.overflow_flag !== want.overflow)
                    report_mismatch("overflow_flag", DATA_W'(rsp_if.overflow_flag),
                                    DATA_W'(want.overflow));
            end
            results_seen++;
        end
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] a,
                             input logic [DATA_W-1:0] b);
        cmd_if.valid     <= 1'b1;
        cmd_if.op        <= op;
        cmd_if.operand_a <= a;
        cmd_if.operand_b <= b;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        expected_results.push_back(alu_predict(op, a, b));
        items_sent++;
    endtask

    task automatic idle_sender(input int cycles);
        cmd_if.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return SIGN_BIT - 1'b1;
            3:       return SIGN_BIT;
            4:       return 16'd1;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_second(input logic [OP_W-1:0] op);
        if (op == OP_LSR || op == OP_LSL || op == OP_ASR)
            return ($urandom_range(0, 9) < 7) ? DATA_W'($urandom_range(0, 17)) : pick_operand();
        if (op == OP_DIV || op == OP_MOD)
        begin
            case ($urandom_range(0, 9))
                0:       return '0;
                1, 2:    return DATA_W'($urandom_range(1, 15));
                default: return pick_operand();
            endcase
        end
        return pick_operand();
    endfunction

    task automatic test_add_sub();
        send_item(OP_ADD, ALL_ONES, 16'd1);
        send_item(OP_ADD, 16'h7FFF, 16'd1);
        send_item(OP_ADD, SIGN_BIT, SIGN_BIT);
        send_item(OP_SUB, 16'd0, 16'd1);
        send_item(OP_SUB, SIGN_BIT, 16'd1);
        send_item(OP_SUB, 16'h7FFF, ALL_ONES);
        idle_sender(3);
    endtask

    task automatic test_shifts();
        send_item(OP_LSR, 16'h8001, 16'd1);
        send_item(OP_LSR, ALL_ONES, ALL_ONES);
        send_item(OP_LSL, 16'd1, 16'd15);
        send_item(OP_LSL, ALL_ONES, 16'd16);
        send_item(OP_ASR, 16'h8001, 16'd4);
        send_item(OP_ASR, SIGN_BIT, 16'd16);
        idle_sender(2);
    endtask

    task automatic test_arith_misc();
        send_item(OP_MOV, 16'h1234, ALL_ONES);
        send_item(OP_MUL, ALL_ONES, ALL_ONES);
        send_item(OP_DIV, ALL_ONES, 16'd0);
        send_item(OP_MOD, 16'h1234, 16'd0);
        send_item(OP_DIV, ALL_ONES, 16'd3);
        send_item(OP_CMP, 16'h5A5A, 16'h5A5A);
        send_item(OP_INC, ALL_ONES, 16'd0);
        send_item(OP_DEC, 16'd0, 16'd0);
        idle_sender(4);
    endtask

    task automatic test_logic_and_unknown();
        send_item(OP_AND, 16'hF0F0, 16'h0FF0);
        send_item(OP_OR, 16'd0, 16'd0);
        send_item(OP_XOR, 16'hAAAA, 16'h5555);
        send_item(OP_NOT, ALL_ONES, 16'd0);
        send_item(5'd16, 16'd0, 16'd0);
        send_item(5'd31, ALL_ONES, ALL_ONES);
        idle_sender(5);
    endtask

    task automatic test_random(input int count, input rx_mode_t mode, input bit no_gaps);
        int burst;
        logic [OP_W-1:0] op;
        rx_mode = mode;
        while (count > 0)
        begin
            burst = no_gaps ? count : $urandom_range(1, 20);
            repeat (burst)
            begin
                op = ($urandom_range(0, 9) == 0) ? OP_W'($urandom_range(16, 31))
                                                 : OP_W'($urandom_range(0, 15));
                send_item(op, pick_operand(), pick_second(op));
                count--;
                if (count == 0)
                    break;
            end
            idle_sender(no_gaps ? 1 : $urandom_range(1, 6));
        end
    endtask

    // receiver held off while items keep coming, so the pipe fills and backs up
    task automatic test_backpressure();
        rx_mode  = RX_ALWAYS;
        hold_req = ~hold_req;
        repeat (40)
            send_item(OP_W'($urandom_range(0, 15)), pick_operand(), pick_operand());
        idle_sender(2);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cmd_if.valid     <= 1'b0;
        cmd_if.op        <= '0;
        cmd_if.operand_a <= '0;
        cmd_if.operand_b <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_add_sub();
        test_shifts();
        test_arith_misc();
        test_logic_and_unknown();
        test_random(RANDOM_ITEMS / 4, RX_ALWAYS, 1'b1);
        test_random(RANDOM_ITEMS / 4, RX_RANDOM, 1'b0);
        test_backpressure();
        test_random(RANDOM_ITEMS / 4, RX_PATTERN, 1'b0);
        test_random(RANDOM_ITEMS / 4, RX_RANDOM, 1'b0);

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d transfers sent and %0d checked over all opcodes incl. unknown codes,",
                 items_sent, results_seen);
        $display("with bursty input, three receiver stall patterns and a %0d-cycle hold-off",
                 longest_hold);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
